// File: rtl/core/dtba_pkg.sv
package dtba_pkg;

  localparam int ROW_W = 13;

  localparam logic [1:0] CFG_DEP_THR   = 2'd0;
  localparam logic [1:0] CFG_BULGE_THR = 2'd1;
  localparam logic [1:0] CFG_RUT_LEN   = 2'd2;

  localparam logic KIND_DEP   = 1'b0;
  localparam logic KIND_BULGE = 1'b1;

  localparam logic signed [15:0] DEP_THR_RST   = -16'sd20;
  localparam logic signed [15:0] BULGE_THR_RST = 16'sd20;
  localparam logic [13:0]        RUT_LEN_RST   = 14'd20;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_end;
  } in_beat_t;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   seed_row;
    logic [3:0]         seed_col;
    logic signed [15:0] extreme;
    logic [16:0]        area;
    logic [13:0]        length;
    logic [3:0]         width;
    logic               is_rut;
    logic               last;
  } out_beat_t;

endpackage

// File: rtl/core/dual_threshold_blob_analyzer.sv
// Labels 8-connected depressions (sample below depression_threshold) and bulges
// (sample above bulge_threshold) in a raster stream COLUMNS wide, and reports one
// beat per blob at the end of the first row that does not touch it, or at frame
// end or the end of row MAX_ROWS-1. Blob records live in one record memory with
// separate read and write ports (one read or write per cycle), which sets the
// timing: an item is accepted and then, per kind, its four neighbors are checked
// with one read per distinct live neighbor blob (at most two, since touching
// neighbors already share a label) and one update. At a row end the slots of each
// kind are scanned, reading each eligible blob, and the blob with the earliest
// seed is emitted; the scan repeats after each emitted blob. A final step ends the
// row. A result beat waits in the output register while the next item is taken.
module dual_threshold_blob_analyzer
  import dtba_pkg::*;
#(
  parameter int COLUMNS    = 13,
  parameter int MAX_ROWS   = 8192,
  parameter int BLOB_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(COLUMNS);
  localparam int SW = $clog2(BLOB_SLOTS);
  localparam int LW = $clog2(BLOB_SLOTS + 1);

  typedef struct packed {
    logic [ROW_W-1:0]   seed_row;
    logic [CW-1:0]      seed_col;
    logic [ROW_W-1:0]   max_row;
    logic [CW-1:0]      min_col;
    logic [CW-1:0]      max_col;
    logic [16:0]        area;
    logic signed [15:0] extreme;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE, S_NB, S_NB_WAIT, S_UPD, S_SC, S_SC_WAIT, S_SC_END, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic kind_r, kind_nxt;
  logic [1:0] nb_idx_r, nb_idx_nxt;
  logic signed [15:0] sample_r, sample_nxt;
  logic fend_r, fend_nxt;
  logic flush_r, flush_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  rec_t acc_r, acc_nxt;
  logic acc_hit_r, acc_hit_nxt;
  logic [SW-1:0] tgt_r, tgt_nxt;
  logic [BLOB_SLOTS-1:0] fold_r, fold_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  rec_t best_r, best_nxt;
  logic best_hit_r, best_hit_nxt;
  logic [SW-1:0] best_slot_r, best_slot_nxt;
  out_beat_t pend_r, pend_nxt;
  logic pend_hit_r, pend_hit_nxt;
  logic out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  logic signed [15:0] dep_thr_r, dep_thr_nxt;
  logic signed [15:0] bulge_thr_r, bulge_thr_nxt;
  logic [13:0] rut_len_r, rut_len_nxt;
  logic [1:0][BLOB_SLOTS-1:0] valid_r, valid_nxt;
  logic [1:0][BLOB_SLOTS-1:0] touched_r, touched_nxt;
  logic [LW-1:0] line_r [2][COLUMNS];
  logic [LW-1:0] line_nxt [2][COLUMNS];
  logic [1:0][LW-1:0] upleft_r, upleft_nxt;

  rec_t blob_mem [2*BLOB_SLOTS];
  rec_t mem_rdata;
  logic mem_we, mem_re;
  logic [SW:0] mem_waddr, mem_raddr;
  rec_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blob_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= blob_mem[mem_raddr];
    end
  end

  function automatic out_beat_t fmt(rec_t b, logic k, logic [13:0] rut);
    logic [13:0] d;
    logic [CW:0] w;
    logic [31:0] w32;
    logic [31:0] sc32;
    out_beat_t o;
    d = {1'b0, b.max_row} - {1'b0, b.seed_row} + 14'd1;
    w = {1'b0, b.max_col} - {1'b0, b.min_col} + (CW+1)'(1);
    w32 = 32'(w);
    sc32 = 32'(b.seed_col);
    o.kind = k;
    o.seed_row = b.seed_row;
    o.seed_col = sc32[3:0];
    o.extreme = b.extreme;
    o.area = b.area;
    o.length = d;
    o.width = w32[3:0];
    if (k != KIND_DEP) begin
      o.is_rut = 1'b0;
    end else if (b.max_row >= b.seed_row) begin
      o.is_rut = d > rut;
    end else begin
      o.is_rut = ({1'b0, b.max_row} + 14'd1) != {1'b0, b.seed_row};
    end
    o.last = 1'b0;
    return o;
  endfunction

  logic [LW-1:0] nb [4];
  logic [LW-1:0] cur, cur_m1;
  logic [SW-1:0] nb_slot;
  logic nb_use, member, dup, out_free;
  logic [SW-1:0] free_slot;
  logic free_ok, hit, row_end, flush_now, elig, scan_last;
  logic [SW-1:0] tslot;
  logic [LW-1:0] lab, em1;
  logic [LW-1:0] rl [COLUMNS];
  rec_t rec, rd;
  logic key_lt;
  out_beat_t pb;

  always_comb begin
    nb[0] = (col_r != '0) ? upleft_r[kind_r] : '0;
    nb[1] = line_r[kind_r][0];
    nb[2] = (col_r != CW'(COLUMNS - 1)) ? line_r[kind_r][1] : '0;
    nb[3] = (col_r != '0) ? line_r[kind_r][COLUMNS-1] : '0;
    cur = nb[nb_idx_r];
    cur_m1 = cur - LW'(1);
    nb_slot = cur_m1[SW-1:0];
    member = kind_r ? (sample_r > bulge_thr_r) : (sample_r < dep_thr_r);
    dup = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(nb_idx_r) && nb[j] == cur) dup = 1'b1;
    end
    nb_use = member && cur != '0 && valid_r[kind_r][nb_slot] && !dup;
    out_free = !out_valid_r || !out_stall;

    free_slot = '0;
    free_ok = 1'b0;
    for (int j = BLOB_SLOTS - 1; j >= 0; j--) begin
      if (!valid_r[kind_r][j]) begin
        free_slot = SW'(j);
        free_ok = 1'b1;
      end
    end
    hit = acc_hit_r || (member && free_ok);
    tslot = acc_hit_r ? tgt_r : free_slot;
    lab = hit ? (LW'(tslot) + LW'(1)) : '0;
    for (int i = 0; i < COLUMNS; i++) begin
      em1 = line_r[kind_r][i] - LW'(1);
      rl[i] = (line_r[kind_r][i] != '0 && fold_r[em1[SW-1:0]]) ? lab : line_r[kind_r][i];
    end
    rec = acc_r;
    if (acc_hit_r) begin
      rec.area = acc_r.area + 17'd1;
      if (row_r > acc_r.max_row) rec.max_row = row_r;
      if (col_r < acc_r.min_col) rec.min_col = col_r;
      if (col_r > acc_r.max_col) rec.max_col = col_r;
      if (kind_r ? (sample_r > acc_r.extreme) : (sample_r < acc_r.extreme)) begin
        rec.extreme = sample_r;
      end
    end else begin
      rec.seed_row = row_r;
      rec.seed_col = col_r;
      rec.max_row = row_r;
      rec.min_col = col_r;
      rec.max_col = col_r;
      rec.area = 17'd1;
      rec.extreme = sample_r;
    end
    row_end = col_r == CW'(COLUMNS - 1);
    flush_now = fend_r || (row_end && (32'(row_r) >= 32'(MAX_ROWS - 1)));
    elig = valid_r[kind_r][scan_r] && (flush_r || !touched_r[kind_r][scan_r]);
    scan_last = scan_r == SW'(BLOB_SLOTS - 1);
    rd = mem_rdata;
    key_lt = {rd.seed_row, rd.seed_col} < {acc_r.seed_row, acc_r.seed_col};
    pb = pend_r;
    pb.last = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    nb_idx_nxt = nb_idx_r;
    sample_nxt = sample_r;
    fend_nxt = fend_r;
    flush_nxt = flush_r;
    col_nxt = col_r;
    row_nxt = row_r;
    acc_nxt = acc_r;
    acc_hit_nxt = acc_hit_r;
    tgt_nxt = tgt_r;
    fold_nxt = fold_r;
    scan_nxt = scan_r;
    best_nxt = best_r;
    best_hit_nxt = best_hit_r;
    best_slot_nxt = best_slot_r;
    pend_nxt = pend_r;
    pend_hit_nxt = pend_hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    dep_thr_nxt = dep_thr_r;
    bulge_thr_nxt = bulge_thr_r;
    rut_len_nxt = rut_len_r;
    valid_nxt = valid_r;
    touched_nxt = touched_r;
    line_nxt = line_r;
    upleft_nxt = upleft_r;
    mem_we = 1'b0;
    mem_waddr = {kind_r, tslot};
    mem_wdata = rec;
    mem_re = 1'b0;
    mem_raddr = {kind_r, nb_slot};

    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEP_THR:   dep_thr_nxt = cfg_data;
        CFG_BULGE_THR: bulge_thr_nxt = cfg_data;
        CFG_RUT_LEN:   rut_len_nxt = cfg_data[13:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_data.sample;
          fend_nxt = in_data.frame_end;
          kind_nxt = KIND_DEP;
          nb_idx_nxt = '0;
          acc_hit_nxt = 1'b0;
          fold_nxt = '0;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (nb_use) begin
          mem_re = 1'b1;
          state_nxt = S_NB_WAIT;
        end else if (nb_idx_r == 2'd3) begin
          state_nxt = S_UPD;
        end else begin
          nb_idx_nxt = nb_idx_r + 2'd1;
        end
      end
      S_NB_WAIT: begin
        if (!acc_hit_r) begin
          acc_nxt = rd;
          tgt_nxt = nb_slot;
        end else begin
          acc_nxt.area = acc_r.area + rd.area;
          if (rd.max_row > acc_r.max_row) acc_nxt.max_row = rd.max_row;
          if (rd.min_col < acc_r.min_col) acc_nxt.min_col = rd.min_col;
          if (rd.max_col > acc_r.max_col) acc_nxt.max_col = rd.max_col;
          if (kind_r ? (rd.extreme > acc_r.extreme) : (rd.extreme < acc_r.extreme)) begin
            acc_nxt.extreme = rd.extreme;
          end
          if (key_lt) begin
            acc_nxt.seed_row = rd.seed_row;
            acc_nxt.seed_col = rd.seed_col;
            tgt_nxt = nb_slot;
          end
        end
        fold_nxt[nb_slot] = 1'b1;
        acc_hit_nxt = 1'b1;
        if (nb_idx_r == 2'd3) begin
          state_nxt = S_UPD;
        end else begin
          nb_idx_nxt = nb_idx_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      S_UPD: begin
        valid_nxt[kind_r] = valid_r[kind_r] & ~fold_r;
        touched_nxt[kind_r] = touched_r[kind_r] & ~fold_r;
        if (hit) begin
          mem_we = 1'b1;
          valid_nxt[kind_r][tslot] = 1'b1;
          touched_nxt[kind_r][tslot] = 1'b1;
        end
        upleft_nxt[kind_r] = rl[0];
        for (int i = 0; i < COLUMNS - 1; i++) begin
          line_nxt[kind_r][i] = rl[i+1];
        end
        line_nxt[kind_r][COLUMNS-1] = lab;
        if (kind_r == KIND_DEP) begin
          kind_nxt = KIND_BULGE;
          nb_idx_nxt = '0;
          acc_hit_nxt = 1'b0;
          fold_nxt = '0;
          state_nxt = S_NB;
        end else begin
          flush_nxt = flush_now;
          if (row_end || flush_now) begin
            kind_nxt = KIND_DEP;
            scan_nxt = '0;
            best_hit_nxt = 1'b0;
            state_nxt = S_SC;
          end else begin
            col_nxt = col_r + CW'(1);
            state_nxt = S_IDLE;
          end
        end
      end
      S_SC: begin
        mem_raddr = {kind_r, scan_r};
        if (elig) begin
          mem_re = 1'b1;
          state_nxt = S_SC_WAIT;
        end else if (scan_last) begin
          state_nxt = S_SC_END;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      S_SC_WAIT: begin
        if (!best_hit_r ||
            {rd.seed_row, rd.seed_col} < {best_r.seed_row, best_r.seed_col}) begin
          best_nxt = rd;
          best_slot_nxt = scan_r;
          best_hit_nxt = 1'b1;
        end
        if (scan_last) begin
          state_nxt = S_SC_END;
        end else begin
          scan_nxt = scan_r + SW'(1);
          state_nxt = S_SC;
        end
      end
      S_SC_END: begin
        if (best_hit_r) begin
          if (!pend_hit_r || out_free) begin
            valid_nxt[kind_r][best_slot_r] = 1'b0;
            if (pend_hit_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt = pend_r;
            end
            pend_nxt = fmt(best_r, kind_r, rut_len_r);
            pend_hit_nxt = 1'b1;
            best_hit_nxt = 1'b0;
            scan_nxt = '0;
            state_nxt = S_SC;
          end
        end else if (kind_r == KIND_DEP) begin
          kind_nxt = KIND_BULGE;
          scan_nxt = '0;
          state_nxt = S_SC;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_hit_r || out_free) begin
          if (pend_hit_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = pb;
          end
          pend_hit_nxt = 1'b0;
          touched_nxt = '0;
          col_nxt = '0;
          if (flush_r) begin
            row_nxt = '0;
            valid_nxt = '0;
            upleft_nxt = '0;
            for (int k = 0; k < 2; k++) begin
              for (int i = 0; i < COLUMNS; i++) begin
                line_nxt[k][i] = '0;
              end
            end
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= KIND_DEP;
      nb_idx_r <= '0;
      flush_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      acc_hit_r <= 1'b0;
      fold_r <= '0;
      scan_r <= '0;
      best_hit_r <= 1'b0;
      pend_hit_r <= 1'b0;
      out_valid_r <= 1'b0;
      dep_thr_r <= DEP_THR_RST;
      bulge_thr_r <= BULGE_THR_RST;
      rut_len_r <= RUT_LEN_RST;
      valid_r <= '0;
      touched_r <= '0;
      upleft_r <= '0;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < COLUMNS; i++) begin
          line_r[k][i] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
      nb_idx_r <= nb_idx_nxt;
      flush_r <= flush_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      acc_hit_r <= acc_hit_nxt;
      fold_r <= fold_nxt;
      scan_r <= scan_nxt;
      best_hit_r <= best_hit_nxt;
      pend_hit_r <= pend_hit_nxt;
      out_valid_r <= out_valid_nxt;
      dep_thr_r <= dep_thr_nxt;
      bulge_thr_r <= bulge_thr_nxt;
      rut_len_r <= rut_len_nxt;
      valid_r <= valid_nxt;
      touched_r <= touched_nxt;
      upleft_r <= upleft_nxt;
      line_r <= line_nxt;
    end
    sample_r <= sample_nxt;
    fend_r <= fend_nxt;
    acc_r <= acc_nxt;
    tgt_r <= tgt_nxt;
    best_r <= best_nxt;
    best_slot_r <= best_slot_nxt;
    pend_r <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!pend_hit_r && !best_hit_r))
    else $error("item taken while a blob beat is pending");

  a_touch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (((touched_r[0] & ~valid_r[0]) == '0) && ((touched_r[1] & ~valid_r[1]) == '0)))
    else $error("touched flag on a free slot");

endmodule

// File: bench/tb_dual_threshold_blob_analyzer.sv
`timescale 1ns / 100ps

module tb_dual_threshold_blob_analyzer;
  import dtba_pkg::*;

  localparam int COLS  = 13;
  localparam int SLOTS = 16;
  localparam int MAXR  = 8192;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    int unsigned seed_row;
    int unsigned seed_col;
    int unsigned max_row;
    int unsigned min_col;
    int unsigned max_col;
    int unsigned area;
    int          extreme;
  } blob_rec_t;

  class blob_scoreboard;
    logic signed [15:0] dep_thr;
    logic signed [15:0] bulge_thr;
    logic [13:0]        rut_len;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [4:0]         line_lbl [2][COLS];
    logic [4:0]         upleft [2];
    blob_rec_t          recs [2][SLOTS];
    bit                 live [2][SLOTS];
    bit                 touched [2][SLOTS];
    out_beat_t          pending [$];
    int                 errors;
    int                 blobs_seen [2];

    function new();
      dep_thr = DEP_THR_RST;
      bulge_thr = BULGE_THR_RST;
      rut_len = RUT_LEN_RST;
      col_pos = 0;
      row_pos = 0;
      errors = 0;
      blobs_seen[0] = 0;
      blobs_seen[1] = 0;
      for (int k = 0; k < 2; k++) begin
        upleft[k] = '0;
        for (int c = 0; c < COLS; c++) line_lbl[k][c] = '0;
        for (int j = 0; j < SLOTS; j++) begin
          live[k][j] = 0;
          touched[k][j] = 0;
        end
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_DEP_THR:   dep_thr = val;
        CFG_BULGE_THR: bulge_thr = val;
        CFG_RUT_LEN:   rut_len = val[13:0];
        default: ;
      endcase
    endfunction

    function bit earlier(int k, int a, int b);
      return {recs[k][a].seed_row, recs[k][a].seed_col[6:0]} <
             {recs[k][b].seed_row, recs[k][b].seed_col[6:0]};
    endfunction

    function void merge_into(int k, int dst, int src);
      recs[k][dst].area = (recs[k][dst].area + recs[k][src].area) & 32'h1FFFF;
      if (recs[k][src].max_row > recs[k][dst].max_row) recs[k][dst].max_row = recs[k][src].max_row;
      if (recs[k][src].min_col < recs[k][dst].min_col) recs[k][dst].min_col = recs[k][src].min_col;
      if (recs[k][src].max_col > recs[k][dst].max_col) recs[k][dst].max_col = recs[k][src].max_col;
      if (k == 0 ? recs[k][src].extreme < recs[k][dst].extreme
                 : recs[k][src].extreme > recs[k][dst].extreme)
        recs[k][dst].extreme = recs[k][src].extreme;
      if (touched[k][src]) touched[k][dst] = 1;
      live[k][src] = 0;
      touched[k][src] = 0;
      for (int c = 0; c < COLS; c++)
        if (line_lbl[k][c] == src + 1) line_lbl[k][c] = dst + 1;
      if (upleft[k] == src + 1) upleft[k] = dst + 1;
    endfunction

    function void label_cell(int k, bit member, int unsigned c, int s);
      int nb [4];
      int tgt;
      int sl;
      tgt = -1;
      nb[0] = (c > 0) ? upleft[k] : 0;
      nb[1] = line_lbl[k][c];
      nb[2] = (c + 1 < COLS) ? line_lbl[k][c + 1] : 0;
      nb[3] = (c > 0) ? line_lbl[k][c - 1] : 0;
      if (member) begin
        for (int i = 0; i < 4; i++) begin
          sl = nb[i] - 1;
          if (sl < 0 || sl >= SLOTS || !live[k][sl]) continue;
          if (tgt < 0 || earlier(k, sl, tgt)) tgt = sl;
        end
        if (tgt >= 0) begin
          for (int i = 0; i < 4; i++) begin
            sl = nb[i] - 1;
            if (sl < 0 || sl >= SLOTS || sl == tgt || !live[k][sl]) continue;
            merge_into(k, tgt, sl);
          end
        end else begin
          for (int j = 0; j < SLOTS; j++)
            if (!live[k][j]) begin
              tgt = j;
              break;
            end
          if (tgt >= 0) begin
            live[k][tgt] = 1;
            recs[k][tgt].seed_row = row_pos;
            recs[k][tgt].seed_col = c;
            recs[k][tgt].max_row = row_pos;
            recs[k][tgt].min_col = c;
            recs[k][tgt].max_col = c;
            recs[k][tgt].area = 0;
            recs[k][tgt].extreme = s;
          end
        end
      end
      upleft[k] = line_lbl[k][c];
      if (tgt >= 0) begin
        recs[k][tgt].area = (recs[k][tgt].area + 1) & 32'h1FFFF;
        if (row_pos > recs[k][tgt].max_row) recs[k][tgt].max_row = row_pos;
        if (c < recs[k][tgt].min_col) recs[k][tgt].min_col = c;
        if (c > recs[k][tgt].max_col) recs[k][tgt].max_col = c;
        if (k == 0 ? s < recs[k][tgt].extreme : s > recs[k][tgt].extreme)
          recs[k][tgt].extreme = s;
        touched[k][tgt] = 1;
        line_lbl[k][c] = tgt + 1;
      end else begin
        line_lbl[k][c] = '0;
      end
    endfunction

    function void release_blobs(int k, bit all, ref int n);
      int best;
      int unsigned len;
      out_beat_t o;
      forever begin
        best = -1;
        for (int j = 0; j < SLOTS; j++) begin
          if (!live[k][j] || (!all && touched[k][j])) continue;
          if (best < 0 || earlier(k, j, best)) best = j;
        end
        if (best < 0) return;
        live[k][best] = 0;
        len = recs[k][best].max_row - recs[k][best].seed_row + 1;
        o.kind     = (k == 0) ? KIND_DEP : KIND_BULGE;
        o.seed_row = recs[k][best].seed_row[12:0];
        o.seed_col = recs[k][best].seed_col[3:0];
        o.extreme  = recs[k][best].extreme[15:0];
        o.area     = recs[k][best].area[16:0];
        o.length   = len[13:0];
        o.width    = 4'(recs[k][best].max_col - recs[k][best].min_col + 1);
        o.is_rut   = (k == 0) && (len > rut_len);
        o.last     = 0;
        pending = {pending, o};
        n++;
      end
    endfunction

    function void note_input(in_beat_t b);
      int s;
      int unsigned c;
      bit row_end;
      bit flush;
      int n;
      s = b.sample;
      c = (col_pos >= COLS) ? 0 : col_pos;
      n = 0;
      label_cell(0, b.sample < dep_thr, c, s);
      label_cell(1, b.sample > bulge_thr, c, s);
      row_end = (c == COLS - 1);
      flush = b.frame_end || (row_end && row_pos >= MAXR - 1);
      if (flush || row_end) begin
        release_blobs(0, flush, n);
        release_blobs(1, flush, n);
        for (int k = 0; k < 2; k++)
          for (int j = 0; j < SLOTS; j++) touched[k][j] = 0;
      end
      if (flush) begin
        for (int k = 0; k < 2; k++) begin
          upleft[k] = '0;
          for (int i = 0; i < COLS; i++) line_lbl[k][i] = '0;
          for (int j = 0; j < SLOTS; j++) live[k][j] = 0;
        end
        col_pos = 0;
        row_pos = 0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 32'h1FFF;
      end else begin
        col_pos = c + 1;
      end
      if (n > 0) pending[$].last = 1;
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      blobs_seen[e.kind]++;
      cmp("kind", e.kind, a.kind);
      cmp("seed_row", e.seed_row, a.seed_row);
      cmp("seed_col", e.seed_col, a.seed_col);
      cmp("extreme", e.extreme, a.extreme);
      cmp("area", e.area, a.area);
      cmp("length", e.length, a.length);
      cmp("width", e.width, a.width);
      cmp("is_rut", e.is_rut, a.is_rut);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  blob_scoreboard sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int items_sent = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;

  dual_threshold_blob_analyzer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 599;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic signed [15:0] s, bit fe);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample: s, frame_end: fe};
    do @(posedge clk); while (in_stall);
    sb.note_input(in_data);
    items_sent++;
    if (fe) frames_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // cat 0 neutral, 1 depression, 2 bulge; falls back to any value when impossible
  function automatic logic signed [15:0] pick_sample(int cat);
    int lo;
    int hi;
    if ($urandom_range(19) == 0) return 16'($urandom);
    lo = -32768;
    hi = 32767;
    case (cat)
      1: hi = int'(sb.dep_thr) - 1;
      2: lo = int'(sb.bulge_thr) + 1;
      default: begin
        lo = sb.dep_thr;
        hi = sb.bulge_thr;
      end
    endcase
    if (lo > hi) return 16'($urandom);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  task automatic random_frames(int n_items);
    int rows;
    int cut;
    int p;
    int cat;
    int goal;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      rows = $urandom_range(1, 6);
      cut = ($urandom_range(3) == 0) ? $urandom_range(COLS - 1) : COLS - 1;
      p = $urandom_range(99);
      for (int r = 0; r < rows && items_sent < goal; r++)
        for (int c = 0; c < COLS && items_sent < goal; c++) begin
          if (r == rows - 1 && c > cut) break;
          cat = ($urandom_range(99) < p) ? $urandom_range(1, 2) : 0;
          send_beat(pick_sample(cat), (r == rows - 1 && c == cut) || items_sent + 1 == goal);
        end
    end
  endtask

  // U-shaped depression that merges late, plus bulges that stay apart; a short frame follows
  logic signed [15:0] dir_px [39] = '{
    -100, 0, 0, 0, -30, 32767, 0, 0, 50, 0, -21, -20, -32768,
    -100, 0, 0, 0, -30, 0, 50, 0, 0, 21, 0, 20, -25,
    -100, -40, -50, -60, 0, 0, 0, 50, 0, 0, -21, 0, 0
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEP_THR;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 7;
    rcv_idle_pct = 81;
    foreach (dir_px[i]) send_beat(dir_px[i], 1'b0);
    send_beat(16'sd32767, 1'b0);
    send_beat(-16'sd32768, 1'b1);
    send_beat(-16'sd500, 1'b1);
    random_frames(100);
    drain();

    write_reg(CFG_DEP_THR, 16'h7FFF);
    write_reg(CFG_BULGE_THR, 16'h8000);
    write_reg(CFG_RUT_LEN, 14'd0);
    snd_idle_pct = 81;
    rcv_idle_pct = 7;
    random_frames(110);
    drain();

    write_reg(CFG_DEP_THR, 16'h8000);
    write_reg(CFG_BULGE_THR, 16'h0000);
    write_reg(CFG_RUT_LEN, 14'd8192);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_go = 1'b1;
    random_frames(110);
    drain();

    write_reg(CFG_DEP_THR, 16'd100);
    write_reg(CFG_BULGE_THR, 16'h7FFF);
    write_reg(CFG_RUT_LEN, 14'd3);
    random_frames(90);
    drain();

    $display("Sent %0d items in %0d frames over four threshold settings;", items_sent,
             frames_sent);
    $display("checked %0d depressions and %0d bulges.", sb.blobs_seen[0], sb.blobs_seen[1]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: dual_threshold_blob_analyzer.f
rtl/core/dtba_pkg.sv
rtl/core/dual_threshold_blob_analyzer.sv
bench/tb_dual_threshold_blob_analyzer.sv
